FILE: src/lsfs_pkg.sv
// ----------------------------------------------------------------------------
// lsfs_pkg
// Shared constants for the LED string frame serializer: register indexes,
// register reset values, frame geometry and request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfs_pkg;

  // configuration register map
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_START_HIGH = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHORT      = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG       = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_END_LOW    = 8'd3;

  // register reset values, in ticks
  localparam logic [CfgDataW-1:0] START_HIGH_RST = 8'd10;
  localparam logic [CfgDataW-1:0] SHORT_RST      = 8'd9;
  localparam logic [CfgDataW-1:0] LONG_RST       = 8'd19;
  localparam logic [CfgDataW-1:0] END_LOW_RST    = 8'd40;

  // frame: 6-bit address, 8-bit intensity, 12-bit color, MSB first
  localparam int unsigned FrameW = 26;
  localparam logic [4:0]  FRAME_BITS = 5'd26;

  // request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CMD  = 1'b1;

endpackage

`default_nettype wire

FILE: src/led_string_frame_serializer_top.sv
// ----------------------------------------------------------------------------
// led_string_frame_serializer_top
// The result word is valid in the cycle after the input word is accepted.
// Throughput: 1 word per cycle while the sink takes results (out_ready); the
// state update and the result register are written in the same cycle as the accept.
// Reset (rst_n low, synchronous): idle, no frames pending, output empty,
// timing registers back to 10/9/19/40 ticks.
// ----------------------------------------------------------------------------
// Single-wire LED string serializer. Command words load a frame batch,
// tick words advance the pulse timer one microsecond and report the pin.
// ----------------------------------------------------------------------------
`default_nettype none

module led_string_frame_serializer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [lsfs_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [lsfs_pkg::CfgDataW-1:0] cfg_data,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_req_type,
  input  wire logic [5:0]                    in_start_address,
  input  wire logic [6:0]                    in_frame_count,
  input  wire logic [7:0]                    in_intensity,
  input  wire logic [3:0]                    in_red,
  input  wire logic [3:0]                    in_green,
  input  wire logic [3:0]                    in_blue,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_pin_level,
  output logic                               out_busy_res,
  output logic                               out_accepted,
  output logic                               out_frame_done
);

  import lsfs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_BLOW  = 3'd2,
    PH_BHIGH = 3'd3,
    PH_END   = 3'd4
  } phase_t;

  // timing registers
  logic [7:0] start_high_r, short_r, long_r, end_low_r;

  // serializer state
  phase_t              phase_r, phase_nxt;
  logic [7:0]          ticks_left_r, ticks_left_nxt;
  logic [FrameW-1:0]   frame_shift_r, frame_shift_nxt;
  logic [4:0]          bits_left_r, bits_left_nxt;
  logic [5:0]          cur_addr_r, cur_addr_nxt;
  logic [6:0]          frames_left_r, frames_left_nxt;
  logic [7:0]          intensity_r, intensity_nxt;
  logic [11:0]         color_r, color_nxt;

  // result register
  logic out_valid_r;
  logic pin_r, pin_nxt;
  logic busy_r, busy_nxt;
  logic acc_r, acc_nxt;
  logic done_r, done_nxt;

  logic accept;
  logic msb;
  logic level_now;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign msb      = frame_shift_r[FrameW-1];

  // pin is high during the start pulse and the high half of a bit
  assign level_now = (phase_r == PH_START) || (phase_r == PH_BHIGH);

  // next state for one accepted word
  always_comb begin
    logic [5:0]  ld_addr;
    logic [7:0]  ld_int;
    logic [11:0] ld_col;
    logic [6:0]  fl_dec;
    logic [5:0]  addr_inc;
    logic [4:0]  bits_dec;
    logic [FrameW-1:0] shl;

    phase_nxt       = phase_r;
    ticks_left_nxt  = ticks_left_r;
    frame_shift_nxt = frame_shift_r;
    bits_left_nxt   = bits_left_r;
    cur_addr_nxt    = cur_addr_r;
    frames_left_nxt = frames_left_r;
    intensity_nxt   = intensity_r;
    color_nxt       = color_r;
    pin_nxt         = 1'b0;
    acc_nxt         = 1'b0;
    done_nxt        = 1'b0;

    ld_addr  = in_start_address;
    ld_int   = in_intensity;
    ld_col   = {in_blue, in_green, in_red};
    fl_dec   = frames_left_r - 7'd1;
    addr_inc = cur_addr_r + 6'd1;
    bits_dec = bits_left_r - 5'd1;
    shl      = {frame_shift_r[FrameW-2:0], 1'b0};

    if (in_req_type == REQ_CMD) begin
      // command: taken only when no frames are pending
      if (frames_left_r == 7'd0) begin
        acc_nxt         = 1'b1;
        cur_addr_nxt    = ld_addr;
        frames_left_nxt = in_frame_count;
        intensity_nxt   = ld_int;
        color_nxt       = ld_col;
        if (in_frame_count != 7'd0) begin
          frame_shift_nxt = {ld_addr, ld_int, ld_col};
          bits_left_nxt   = FRAME_BITS;
          phase_nxt       = PH_START;
          ticks_left_nxt  = start_high_r;
          pin_nxt         = 1'b1;
        end else begin
          phase_nxt = PH_IDLE;
          pin_nxt   = 1'b0;
        end
      end else begin
        pin_nxt = level_now;
      end
    end else begin
      // tick: report level, then advance the timer
      pin_nxt = level_now;
      if (ticks_left_r > 8'd1 && phase_r != PH_IDLE) begin
        ticks_left_nxt = ticks_left_r - 8'd1;
      end else begin
        case (phase_r)
          PH_START: begin
            phase_nxt      = PH_BLOW;
            ticks_left_nxt = msb ? long_r : short_r;
          end
          PH_BLOW: begin
            phase_nxt      = PH_BHIGH;
            ticks_left_nxt = msb ? short_r : long_r;
          end
          PH_BHIGH: begin
            frame_shift_nxt = shl;
            bits_left_nxt   = bits_dec;
            if (bits_dec == 5'd0) begin
              phase_nxt      = PH_END;
              ticks_left_nxt = end_low_r;
            end else begin
              phase_nxt      = PH_BLOW;
              ticks_left_nxt = shl[FrameW-1] ? long_r : short_r;
            end
          end
          PH_END: begin
            done_nxt        = 1'b1;
            frames_left_nxt = fl_dec;
            cur_addr_nxt    = addr_inc;
            if (fl_dec != 7'd0) begin
              frame_shift_nxt = {addr_inc, intensity_r, color_r};
              bits_left_nxt   = FRAME_BITS;
              phase_nxt       = PH_START;
              ticks_left_nxt  = start_high_r;
            end else begin
              phase_nxt      = PH_IDLE;
              ticks_left_nxt = 8'd0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end

    busy_nxt = (frames_left_nxt != 7'd0);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_high_r <= START_HIGH_RST;
      short_r      <= SHORT_RST;
      long_r       <= LONG_RST;
      end_low_r    <= END_LOW_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START_HIGH: start_high_r <= cfg_data;
        CFG_SHORT:      short_r      <= cfg_data;
        CFG_LONG:       long_r       <= cfg_data;
        CFG_END_LOW:    end_low_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // serializer state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      ticks_left_r  <= '0;
      frame_shift_r <= '0;
      bits_left_r   <= '0;
      cur_addr_r    <= '0;
      frames_left_r <= '0;
      intensity_r   <= '0;
      color_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        ticks_left_r  <= ticks_left_nxt;
        frame_shift_r <= frame_shift_nxt;
        bits_left_r   <= bits_left_nxt;
        cur_addr_r    <= cur_addr_nxt;
        frames_left_r <= frames_left_nxt;
        intensity_r   <= intensity_nxt;
        color_r       <= color_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      pin_r  <= pin_nxt;
      busy_r <= busy_nxt;
      acc_r  <= acc_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_level  = pin_r;
  assign out_busy_res   = busy_r;
  assign out_accepted   = acc_r;
  assign out_frame_done = done_r;

endmodule

`default_nettype wire

FILE: src/lsfs_checker.sv
// ----------------------------------------------------------------------------
// lsfs_checker
// Port-level checks for the LED string frame serializer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_req_type,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_pin_level,
  input wire logic out_accepted,
  input wire logic out_frame_done
);

  import lsfs_pkg::*;

  // every accepted word yields a result word in the next cycle
  a_word_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted word produced no result");

  // a tick word is never reported as an accepted command
  a_tick_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == REQ_TICK) |=> !out_accepted)
    else $error("tick word flagged as accepted");

  // frame end only on a tick, and the end gap drives the pin low
  a_done_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (!out_accepted && !out_pin_level))
    else $error("frame done with command or high pin");

  // a result waiting for the sink stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind led_string_frame_serializer_top lsfs_checker u_lsfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_req_type   (in_req_type),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pin_level (out_pin_level),
  .out_accepted  (out_accepted),
  .out_frame_done(out_frame_done)
);

`default_nettype wire
